### rtl/bppr_pkg.sv
// Package for the buffer pool page replacement unit.
// Holds op, status, policy and config codes, widths and the result record for the top level.
package bppr_pkg;
  localparam logic [2:0] OP_PIN   = 3'd0;
  localparam logic [2:0] OP_UNPIN = 3'd1;
  localparam logic [2:0] OP_DIRTY = 3'd2;
  localparam logic [2:0] OP_FORCE = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LOADED  = 3'd1;
  localparam logic [2:0] ST_REPLACE = 3'd2;
  localparam logic [2:0] ST_NOTFND  = 3'd3;
  localparam logic [2:0] ST_ALLPIN  = 3'd4;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;
  localparam logic [1:0] POL_LFU   = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  localparam int PAGE_W = 31;
  localparam int CNT_W  = 32;
  localparam int PIN_W  = 16;
  localparam int IDX_W  = 4;
  localparam int MAXN   = 16;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  frame;
    logic              rd_v;
    logic [PAGE_W-1:0] rd_page;
    logic              wr_v;
    logic [PAGE_W-1:0] wr_page;
    logic              last;
  } result_t;
endpackage

### rtl/buffer_pool_page_replacement_unit.sv
// Buffer pool page replacement unit: frame metadata and a sequencer that visits one frame a cycle
// except while a flush result waits on out_stall. A pin looks up its page, on a miss searches
// for an empty frame, then if none scans for a victim (CLOCK may pass the frames twice) and fills
// the frame. Unpin, dirty and force only look up; a flush writes back each dirty unpinned frame.
// Throughput: one item at a time; in_stall holds until the last result transfers.
// Reset (synchronous, active low) empties all frames, restores counters, policy and frame count.
module buffer_pool_page_replacement_unit #(
  parameter int FRAMES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [4:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_op,
  input  logic [bppr_pkg::PAGE_W-1:0]  in_page_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [3:0]                   out_frame_index,
  output logic                         out_read_valid,
  output logic [bppr_pkg::PAGE_W-1:0]  out_read_page,
  output logic                         out_write_valid,
  output logic [bppr_pkg::PAGE_W-1:0]  out_write_page,
  output logic                         out_last,
  output logic [31:0]                  out_read_ios,
  output logic [31:0]                  out_write_ios
);
  localparam int NF = (FRAMES < bppr_pkg::MAXN) ? FRAMES : bppr_pkg::MAXN;
  localparam int IW = bppr_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_EMPT = 3'd2;
  localparam logic [2:0] S_VICT = 3'd3;
  localparam logic [2:0] S_FLSH = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_APPL = 3'd6;

  logic [bppr_pkg::PAGE_W-1:0] pg_r [NF];
  logic [NF-1:0] val_r, dty_r;
  logic [bppr_pkg::PIN_W-1:0] pin_r [NF];
  logic [31:0] rec_r [NF];
  logic [31:0] use_r [NF];
  logic [31:0] stamp_r, fifo_r, rdc_r, wrc_r;
  logic [IW-1:0] hand_r, lfu_r;
  logic [1:0] pol_r;
  logic [4:0] fiu_r;

  logic [2:0] st_r;
  logic [2:0] op_r;
  logic [bppr_pkg::PAGE_W-1:0] ipg_r;
  logic [IW:0] cnt_r;      // steps taken in the current scan
  logic [IW-1:0] f_r;      // frame under the scan
  logic best_v_r;
  logic [IW-1:0] best_r;
  logic any_r;             // flush produced a result, or a pin saw an unpinned frame
  logic outv_r;
  bppr_pkg::result_t res_r;

  logic [IW:0] n;
  always_comb begin
    n = fiu_r;
    if (n == '0) n = (IW+1)'(1);
    if (n > (IW+1)'(NF)) n = (IW+1)'(NF);
  end

  logic [IW:0] nm1;
  assign nm1 = n - 1'b1;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] f, input logic [IW:0] nn);
    logic [IW:0] t;
    t = {1'b0, f} + 1'b1;
    wrap_inc = (t >= nn) ? '0 : t[IW-1:0];
  endfunction

  // small index mod n by shifted compare and subtract
  function automatic logic [IW-1:0] mod_n(input logic [IW-1:0] v, input logic [IW:0] nn);
    logic [2*IW:0] r;
    logic [2*IW:0] d;
    r = (2*IW+1)'(v);
    for (int k = IW-1; k >= 0; k--) begin
      d = (2*IW+1)'(nn) << k;
      if (r >= d) r = r - d;
    end
    mod_n = r[IW-1:0];
  endfunction
  // fifo_pointer mod m for every frame count m = k+1, advanced with each fill
  logic [IW-1:0] fres_r [NF];

  wire [IW-1:0] fi = f_r;
  wire cur_free = (pin_r[fi] == '0);

  assign in_stall  = (st_r != S_IDLE) || cfg_we;
  assign out_valid = outv_r;
  assign out_status = res_r.status;
  assign out_frame_index = 4'(res_r.frame);
  assign out_read_valid = res_r.rd_v;
  assign out_read_page = res_r.rd_page;
  assign out_write_valid = res_r.wr_v;
  assign out_write_page = res_r.wr_page;
  assign out_last = res_r.last;
  assign out_read_ios = rdc_r;
  assign out_write_ios = wrc_r;

  bppr_pkg::result_t r0;
  always_comb begin
    r0 = '0;
    r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; outv_r <= 1'b0; val_r <= '0; dty_r <= '0;
      stamp_r <= '0; fifo_r <= '0; rdc_r <= '0; wrc_r <= '0;
      hand_r <= '0; lfu_r <= '0; pol_r <= bppr_pkg::POL_FIFO; fiu_r <= 5'd16;
      for (int i = 0; i < NF; i++) begin
        pg_r[i] <= '0; pin_r[i] <= '0; rec_r[i] <= '0; use_r[i] <= '0;
        fres_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == bppr_pkg::CFG_POLICY) pol_r <= cfg_data[1:0];
        else fiu_r <= cfg_data;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_op; ipg_r <= in_page_number;
            f_r <= '0; cnt_r <= '0; any_r <= 1'b0;
            st_r <= (in_op == bppr_pkg::OP_FLUSH) ? S_FLSH :
                    (in_op > bppr_pkg::OP_FLUSH) ? S_OUT : S_FIND;
            res_r <= r0;
            if (in_op > bppr_pkg::OP_FLUSH) begin
              res_r.status <= bppr_pkg::ST_NOTFND;
              outv_r <= 1'b1;
            end
          end
        end
        S_FIND: begin
          if (cnt_r == n) begin
            if (op_r == bppr_pkg::OP_PIN) begin
              st_r <= S_EMPT; f_r <= '0; cnt_r <= '0; best_v_r <= 1'b0;
            end else begin
              res_r <= r0; res_r.status <= bppr_pkg::ST_NOTFND;
              outv_r <= 1'b1; st_r <= S_OUT;
            end
          end else if (val_r[fi] && pg_r[fi] == ipg_r) begin
            res_r <= r0; res_r.frame <= fi; outv_r <= 1'b1; st_r <= S_OUT;
            case (op_r)
              bppr_pkg::OP_PIN: begin
                if (pin_r[fi] != '1) pin_r[fi] <= pin_r[fi] + 1'b1;
                stamp_r <= stamp_r + 1;
                if (pol_r == bppr_pkg::POL_LRU) rec_r[fi] <= stamp_r + 1;
                else if (pol_r == bppr_pkg::POL_CLOCK) rec_r[fi] <= 32'd1;
                else if (pol_r == bppr_pkg::POL_LFU) use_r[fi] <= use_r[fi] + 1;
              end
              bppr_pkg::OP_UNPIN: if (pin_r[fi] != '0) pin_r[fi] <= pin_r[fi] - 1'b1;
              bppr_pkg::OP_DIRTY: dty_r[fi] <= 1'b1;
              default: begin
                wrc_r <= wrc_r + 1; dty_r[fi] <= 1'b0;
                res_r.wr_v <= 1'b1; res_r.wr_page <= pg_r[fi];
              end
            endcase
          end else begin
            f_r <= wrap_inc(f_r, n); cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EMPT: begin
          if (cnt_r == n) begin
            if (!any_r) begin
              // every frame pinned: report and leave all state alone
              res_r <= r0; res_r.status <= bppr_pkg::ST_ALLPIN;
              outv_r <= 1'b1; st_r <= S_OUT;
            end else begin
              st_r <= S_VICT; cnt_r <= '0; best_v_r <= 1'b0;
              case (pol_r)
                bppr_pkg::POL_FIFO:  f_r <= fres_r[nm1[IW-1:0]];
                bppr_pkg::POL_LFU:   f_r <= mod_n(lfu_r, n);
                bppr_pkg::POL_CLOCK: f_r <= mod_n(hand_r, n);
                default: f_r <= '0;
              endcase
            end
          end else if (!val_r[fi]) begin
            best_r <= fi; st_r <= S_APPL; best_v_r <= 1'b1;
            res_r <= r0; res_r.status <= bppr_pkg::ST_LOADED;
          end else begin
            if (cur_free) any_r <= 1'b1;
            f_r <= wrap_inc(f_r, n); cnt_r <= cnt_r + 1'b1;
          end
        end
        S_VICT: begin
          // LRU/LFU visit n frames, FIFO stops at the first unpinned one; CLOCK up to 2n+1
          if ((pol_r != bppr_pkg::POL_CLOCK && cnt_r == n) ||
              (pol_r == bppr_pkg::POL_CLOCK && {1'b0, cnt_r} == {n, 1'b0} + 1'b1)) begin
            if (best_v_r) begin
              st_r <= S_APPL; res_r <= r0; res_r.status <= bppr_pkg::ST_REPLACE;
              if (pol_r == bppr_pkg::POL_LFU) lfu_r <= wrap_inc(best_r, n);
            end else begin
              res_r <= r0; res_r.status <= bppr_pkg::ST_ALLPIN;
              outv_r <= 1'b1; st_r <= S_OUT;
            end
          end else begin
            f_r <= wrap_inc(f_r, n); cnt_r <= cnt_r + 1'b1;
            case (pol_r)
              bppr_pkg::POL_FIFO:
                if (cur_free && !best_v_r) begin
                  best_v_r <= 1'b1; best_r <= fi; cnt_r <= n;
                end
              bppr_pkg::POL_LRU:
                if (cur_free && (!best_v_r || rec_r[fi] < rec_r[best_r])) begin
                  best_v_r <= 1'b1; best_r <= fi;
                end
              bppr_pkg::POL_LFU:
                if (cur_free && (!best_v_r || use_r[fi] < use_r[best_r])) begin
                  best_v_r <= 1'b1; best_r <= fi;
                end
              default:
                if (cur_free && rec_r[fi] == '0) begin
                  best_v_r <= 1'b1; best_r <= fi;
                  hand_r <= wrap_inc(fi, n);
                  st_r <= S_APPL; res_r <= r0; res_r.status <= bppr_pkg::ST_REPLACE;
                end else begin
                  rec_r[fi] <= '0;
                end
            endcase
          end
        end
        S_APPL: begin
          stamp_r <= stamp_r + 1; fifo_r <= fifo_r + 1;
          for (int k = 0; k < NF; k++)
            fres_r[k] <= (fres_r[k] == IW'(k)) ? '0 : fres_r[k] + 1'b1;
          pg_r[best_r] <= ipg_r; val_r[best_r] <= 1'b1; dty_r[best_r] <= 1'b0;
          pin_r[best_r] <= bppr_pkg::PIN_W'(1); use_r[best_r] <= '0;
          rec_r[best_r] <= (pol_r == bppr_pkg::POL_LRU) ? stamp_r + 1 :
                           (pol_r == bppr_pkg::POL_CLOCK) ? 32'd1 : 32'd0;
          res_r.frame <= best_r; res_r.rd_v <= 1'b1; res_r.rd_page <= ipg_r;
          if (res_r.status == bppr_pkg::ST_REPLACE && dty_r[best_r]) begin
            wrc_r <= wrc_r + 1; res_r.wr_v <= 1'b1; res_r.wr_page <= pg_r[best_r];
          end
          // fill always reads one page
          rdc_r <= rdc_r + 1;
          outv_r <= 1'b1; st_r <= S_OUT;
        end
        S_FLSH: begin
          if (!outv_r) begin
            if (cnt_r == n) begin
              if (!any_r) begin
                res_r <= r0; outv_r <= 1'b1; st_r <= S_OUT;
              end else begin
                st_r <= S_IDLE;
              end
            end else begin
              f_r <= wrap_inc(f_r, n); cnt_r <= cnt_r + 1'b1;
              if (val_r[fi] && cur_free && dty_r[fi]) begin
                any_r <= 1'b1; wrc_r <= wrc_r + 1; dty_r[fi] <= 1'b0;
                res_r <= r0; res_r.frame <= fi; res_r.wr_v <= 1'b1;
                res_r.wr_page <= pg_r[fi];
                res_r.last <= 1'b1;
                // last unless another valid, unpinned, dirty frame follows
                for (int j = 0; j < NF; j++)
                  if (j > int'(fi) && (IW+1)'(j) < n && val_r[j] &&
                      pin_r[j] == '0 && dty_r[j])
                    res_r.last <= 1'b0;
                outv_r <= 1'b1;
              end
            end
          end else if (!out_stall) begin
            outv_r <= 1'b0;
            if (res_r.last) st_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            outv_r <= 1'b0; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
